@@ src/sfs_pkg.sv @@
`timescale 1ns / 1ps

package sfs_pkg;

    localparam int MAX_FRAMES  = 256;
    localparam int STATE_LIMIT = 256;
    localparam int FRAME_LIMIT = (MAX_FRAMES < STATE_LIMIT) ? MAX_FRAMES : STATE_LIMIT;

    // Dividend width covers the largest accumulator sum plus a frame offset.
    localparam int DIV_W = 26;
    localparam int REM_W = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_PLAY_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAY_LENGTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ANIM_COUNT  = 3'd4;

    localparam logic [1:0] MODE_PAUSED    = 2'd0;
    localparam logic [1:0] MODE_FORWARDS  = 2'd1;
    localparam logic [1:0] MODE_BACKWARDS = 2'd2;
    localparam logic [1:0] MODE_UNKNOWN   = 2'd3;

    localparam logic [1:0] REQ_TICK      = 2'd0;
    localparam logic [1:0] REQ_SET_FRAME = 2'd1;
    localparam logic [1:0] REQ_SET_ANIM  = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] elapsed_ms;
        logic [7:0]  target_index;
    } in_t;

    typedef struct packed {
        logic [7:0] frame_now;
        logic [7:0] animation_now;
    } out_t;

    function automatic logic [8:0] eff_count(input logic [8:0] c, input logic [8:0] limit);
        logic [8:0] r;
        if (c == 9'd0)
        begin
            r = 9'd1;
        end
        else if (c > limit)
        begin
            r = limit;
        end
        else
        begin
            r = c;
        end
        return r;
    endfunction

endpackage

@@ src/sprite_frame_sequencer_unit.sv @@
`timescale 1ns / 1ps

// Set-frame, set-animation, unused and paused-tick transactions go from acceptance straight to the done state.
// A running tick goes through multiply, first division and, when a looping frame wraps, a second division before done.
// Both tick divisions run one quotient bit per cycle through one shared 26-step divider.
// One transaction is in flight at a time; the input stalls until its result is registered.
// Reset is asynchronous and restores the register defaults and clears all positions.

module sprite_frame_sequencer_unit
    import sfs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_t                   in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_t                  out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DIV1 = 3'd2;
    localparam logic [2:0] S_DIV2 = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [1:0]  mode_reg;
    logic        loop_reg;
    logic [15:0] len_reg;
    logic [8:0]  fcount_reg;
    logic [8:0]  acount_reg;
    logic [7:0]  frame_reg, frame_next;
    logic [7:0]  anim_reg, anim_next;
    logic [15:0] acc_reg;
    logic [24:0] prod_reg;
    logic        out_valid_reg;
    out_t        out_reg;

    logic [8:0]  fc;
    logic [8:0]  ac;
    logic [7:0]  last;
    logic [15:0] len_eff;
    logic        accept;
    logic        slot_free;

    logic             div_start;
    logic [DIV_W-1:0] div_dividend;
    logic [REM_W-1:0] div_divisor;
    logic             div_busy;
    logic             div_done;
    logic [DIV_W-1:0] div_quo;
    logic [REM_W-1:0] div_rem;

    logic [DIV_W-1:0] frame_ext;
    logic [DIV_W-1:0] fpn;
    logic [DIV_W-1:0] mod_arg;

    assign fc        = eff_count(fcount_reg, 9'(FRAME_LIMIT));
    assign ac        = eff_count(acount_reg, 9'(STATE_LIMIT));
    assign last      = 8'(fc - 9'd1);
    assign len_eff   = (len_reg == 16'd0) ? 16'd1 : len_reg;
    assign accept    = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);

    assign frame_ext = DIV_W'(frame_reg);
    assign fpn       = frame_ext + div_quo;

    always_comb
    begin
        if (mode_reg == MODE_FORWARDS)
        begin
            mod_arg = (9'(frame_reg) >= fc) ? (div_quo - DIV_W'(1)) : fpn;
        end
        else
        begin
            mod_arg = div_quo - frame_ext - DIV_W'(1);
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        frame_next   = frame_reg;
        anim_next    = anim_reg;
        div_start    = 1'b0;
        div_dividend = mod_arg;
        div_divisor  = REM_W'(fc);
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DONE;
                    unique case (in_data.req_type)
                        REQ_TICK:
                        begin
                            if (mode_reg != MODE_PAUSED)
                            begin
                                state_next = S_MUL;
                            end
                        end
                        REQ_SET_FRAME:
                        begin
                            frame_next = (9'(in_data.target_index) < fc) ?
                                         in_data.target_index : last;
                        end
                        REQ_SET_ANIM:
                        begin
                            anim_next  = (9'(in_data.target_index) < ac) ?
                                         in_data.target_index : 8'(ac - 9'd1);
                            frame_next = 8'd0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(acc_reg) + DIV_W'(prod_reg);
                div_divisor  = len_eff;
                state_next   = S_DIV1;
            end
            S_DIV1:
            begin
                if (div_done)
                begin
                    state_next = S_DONE;
                    if (mode_reg == MODE_UNKNOWN || div_quo == '0)
                    begin
                        frame_next = frame_reg;
                    end
                    else if (mode_reg == MODE_FORWARDS)
                    begin
                        if (fpn < DIV_W'(fc))
                        begin
                            frame_next = fpn[7:0];
                        end
                        else if (!loop_reg)
                        begin
                            frame_next = last;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV2;
                        end
                    end
                    else
                    begin
                        if (div_quo <= frame_ext)
                        begin
                            frame_next = frame_reg - div_quo[7:0];
                        end
                        else if (!loop_reg)
                        begin
                            frame_next = 8'd0;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV2;
                        end
                    end
                end
            end
            S_DIV2:
            begin
                if (div_done)
                begin
                    state_next = S_DONE;
                    frame_next = (mode_reg == MODE_FORWARDS) ? div_rem[7:0] : last - div_rem[7:0];
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    sfs_divider #(
        .DW (DIV_W),
        .VW (REM_W)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= MODE_PAUSED;
            loop_reg      <= 1'b1;
            len_reg       <= 16'd1000;
            fcount_reg    <= 9'd1;
            acount_reg    <= 9'd1;
            frame_reg     <= 8'd0;
            anim_reg      <= 8'd0;
            acc_reg       <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            frame_reg <= frame_next;
            anim_reg  <= anim_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_PLAY_MODE:   mode_reg   <= cfg_data[1:0];
                    CFG_LOOP_ENABLE: loop_reg   <= cfg_data[0];
                    CFG_PLAY_LENGTH: len_reg    <= cfg_data;
                    CFG_FRAME_COUNT: fcount_reg <= cfg_data[8:0];
                    CFG_ANIM_COUNT:  acount_reg <= cfg_data[8:0];
                    default:         ;
                endcase
            end
            if (cfg_we && cfg_index == CFG_PLAY_MODE)
            begin
                acc_reg <= 16'd0;
            end
            else if (state_reg == S_DIV1 && div_done)
            begin
                acc_reg <= div_rem;
            end
            if (state_reg == S_DONE && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prod_reg <= 25'(in_data.elapsed_ms) * 25'(fc);
        end
        if (state_reg == S_DONE && slot_free)
        begin
            out_reg.frame_now     <= frame_reg;
            out_reg.animation_now <= anim_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef NO_ASSERTIONS
    a_stall_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("Input not stalled while a transaction is in flight.");

    a_done_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV1 || state_reg == S_DIV2))
        else $error("Divider completed outside a divide state.");

    a_busy_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> (state_reg == S_DIV1 || state_reg == S_DIV2))
        else $error("Divider iterating outside a divide state.");

    a_result_delivered: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && slot_free) |=> (out_valid && state_reg == S_IDLE))
        else $error("Finished transaction not presented at the output.");
`endif

endmodule

@@ src/sfs_divider.sv @@
`timescale 1ns / 1ps

module sfs_divider
    import sfs_pkg::*;
#(
    parameter int DW = DIV_W,
    parameter int VW = REM_W
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          busy,
    output logic          done,
    output logic [DW-1:0] quotient,
    output logic [VW-1:0] remainder
);

    localparam int CW = $clog2(DW + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          done_reg, done_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [VW-1:0] dvs_reg, dvs_next;

    logic [VW:0] trial;
    logic [VW:0] diff;
    logic        fits;

    assign trial = {rem_reg, quo_reg[DW-1]};
    assign fits  = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            cnt_next = CW'(DW);
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = fits ? diff[VW-1:0] : trial[VW-1:0];
            quo_next  = {quo_reg[DW-2:0], fits};
            cnt_next  = cnt_reg - CW'(1);
            done_next = (cnt_reg == CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy      = (cnt_reg != '0);
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

`ifndef NO_ASSERTIONS
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rem_reg < dvs_reg))
        else $error("Remainder not below divisor at completion.");

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy)
        else $error("Divider started while busy.");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("Divider flagged done while still iterating.");
`endif

endmodule
